// ===== hw/rtl/edd_pkg.sv =====
// ----------------------------------------------------------------------------
// edd_pkg
// Shared constants, types and helpers for the encrypted data detector.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int MAX_BYTES     = 4096;
  localparam int SEARCH_WINDOW = 128;
  localparam int FRAC_BITS     = 12;
  localparam int LOG_FRAC      = 24;

  localparam logic [15:0] THRESH_RESET  = 16'd32563;
  localparam logic [12:0] MIN_RESET     = 13'd256;
  localparam logic [15:0] ENTROPY_CAP   = 16'd32768;

  // register indexes
  localparam logic CFG_THRESH  = 1'b0;
  localparam logic CFG_MIN_LEN = 1'b1;

  // verdict codes
  localparam logic [2:0] V_SHORT  = 3'd0;
  localparam logic [2:0] V_PLAIN  = 3'd1;
  localparam logic [2:0] V_LUKS   = 3'd2;
  localparam logic [2:0] V_FVE    = 3'd3;
  localparam logic [2:0] V_SALTED = 3'd4;
  localparam logic [2:0] V_HIGH   = 3'd5;

  localparam logic [0:5][7:0] LUKS_MAGIC =
    {8'h4C, 8'h55, 8'h4B, 8'h53, 8'hBA, 8'hBE};
  localparam logic [0:7][7:0] SALTED_MAGIC =
    {8'h53, 8'h61, 8'h6C, 8'h74, 8'h65, 8'h64, 8'h5F, 8'h5F};
  localparam logic [63:0] FVE_MAGIC = 64'h2D4656452D46532D;

  typedef enum logic [1:0] {LG_IDLE, LG_SQR, LG_MUL} lg_state_t;

  typedef enum logic [3:0] {
    T_IDLE, T_WR, T_DEC, T_BRD, T_BST, T_BWT, T_TOP, T_TWT, T_DIV, T_CMP, T_OUT
  } top_state_t;

  // index of the highest set bit
  function automatic logic [3:0] msb13(input logic [12:0] c);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i < 13; i++) begin
      if (c[i]) k = 4'(i);
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/encrypted_data_detector_core.sv =====
// ----------------------------------------------------------------------------
// encrypted_data_detector_core
// Byte histogram, signature tracking and entropy verdict on a byte stream.
// ----------------------------------------------------------------------------
// Each byte is read from the histogram in T_IDLE and written back in T_WR; in_stall holds off the next byte meanwhile.
// On a last byte: a decision state (T_DEC), plus for the entropy test a walk of 256
// bins through the shared c*log2(c) unit (its 24 squaring steps dominate),
// one more log, and a restoring divide for a 28-bit quotient.
// Reset (rst_n low, synchronous) clears histogram valid bits, signature state,
// and loads threshold 32563 and minimum length 256; no clearing pass needed.
// ----------------------------------------------------------------------------
module encrypted_data_detector_core import edd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_encrypted,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_entropy_value,
  output logic [12:0] out_bytes_counted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // histogram memory; per-bin valid bits give the all-zero reset at once
  logic [12:0]  hist_mem [256];
  logic [255:0] vld_r;
  logic [12:0]  rd_data_r;
  logic         rd_vld_r;
  logic [7:0]   rd_addr;
  logic [12:0]  cnt;

  top_state_t   state_r, state_nxt;
  logic [15:0]  thresh_r;
  logic [12:0]  min_r;
  logic [7:0]   byte_r, byte_nxt;
  logic         last_r, last_nxt;
  logic [12:0]  total_r, total_nxt;
  logic [55:0]  recent_r, recent_nxt;
  logic         luks_r, luks_nxt, salt_r, salt_nxt, fve_r, fve_nxt;
  logic [7:0]   idx_r, idx_nxt;
  logic [27:0]  sum_r, sum_nxt;
  logic [13:0]  rem_r, rem_nxt;
  logic [27:0]  quo_r, quo_nxt;
  logic [4:0]   dcnt_r, dcnt_nxt;
  logic [2:0]   verd_r, verd_nxt;
  logic [15:0]  ent_r, ent_nxt;
  logic         wr_en, clr;

  logic         ov_r, ov_nxt;
  logic         oenc_r, oenc_nxt;
  logic [2:0]   over_r, over_nxt;
  logic [15:0]  oent_r, oent_nxt;
  logic [12:0]  ocnt_r, ocnt_nxt;

  logic         lg_start, lg_done;
  logic [12:0]  lg_c;
  logic [27:0]  lg_val;
  logic [63:0]  win;
  logic [13:0]  tr;
  logic         acc;

  edd_clogc u_clogc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .c     (lg_c),
    .done  (lg_done),
    .value (lg_val)
  );

  assign in_stall  = (state_r != T_IDLE);
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign rd_addr   = (state_r == T_IDLE) ? in_data_byte : idx_r;
  assign cnt       = rd_vld_r ? rd_data_r : 13'd0;
  assign win       = {recent_r, in_data_byte};
  assign tr        = {rem_r[12:0], quo_r[27]};
  assign wr_en     = (state_r == T_WR);

  assign out_valid         = ov_r;
  assign out_encrypted     = oenc_r;
  assign out_verdict       = over_r;
  assign out_entropy_value = oent_r;
  assign out_bytes_counted = ocnt_r;

  // memory
  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[byte_r] <= cnt + 13'd1;
    rd_data_r <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[byte_r] <= 1'b1;
    end
    rd_vld_r <= vld_r[rd_addr];
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      min_r    <= MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESH:  thresh_r <= cfg_data;
        CFG_MIN_LEN: min_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      total_r  <= '0;
      recent_r <= '0;
      luks_r   <= 1'b1;
      salt_r   <= 1'b1;
      fve_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      recent_r <= recent_nxt;
      luks_r   <= luks_nxt;
      salt_r   <= salt_nxt;
      fve_r    <= fve_nxt;
      ov_r     <= ov_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    verd_r <= verd_nxt;
    ent_r  <= ent_nxt;
    oenc_r <= oenc_nxt;
    over_r <= over_nxt;
    oent_r <= oent_nxt;
    ocnt_r <= ocnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    total_nxt  = total_r;
    recent_nxt = recent_r;
    luks_nxt   = luks_r;
    salt_nxt   = salt_r;
    fve_nxt    = fve_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    verd_nxt   = verd_r;
    ent_nxt    = ent_r;
    ov_nxt     = ov_r && out_stall;
    oenc_nxt   = oenc_r;
    over_nxt   = over_r;
    oent_nxt   = oent_r;
    ocnt_nxt   = ocnt_r;
    lg_start   = 1'b0;
    lg_c       = cnt;
    clr        = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (acc) begin
          byte_nxt = in_data_byte;
          last_nxt = in_last_byte;
          if (total_r < 13'(MAX_BYTES)) begin
            if (total_r < 13'd6 && in_data_byte != LUKS_MAGIC[total_r[2:0]])
              luks_nxt = 1'b0;
            if (total_r < 13'd8 && in_data_byte != SALTED_MAGIC[total_r[2:0]])
              salt_nxt = 1'b0;
            if (total_r < 13'(SEARCH_WINDOW)) begin
              if (total_r >= 13'd7 && win == FVE_MAGIC) fve_nxt = 1'b1;
              recent_nxt = win[55:0];
            end
            total_nxt = total_r + 13'd1;
            state_nxt = T_WR;
          end else if (in_last_byte) begin
            state_nxt = T_DEC;
          end
        end
      end
      T_WR: state_nxt = last_r ? T_DEC : T_IDLE;
      T_DEC: begin
        ent_nxt   = 16'd0;
        state_nxt = T_OUT;
        if (total_r < 13'd8)                 verd_nxt = V_SHORT;
        else if (total_r >= 13'd16 && luks_r) verd_nxt = V_LUKS;
        else if (total_r >= 13'd16 && fve_r)  verd_nxt = V_FVE;
        else if (total_r >= 13'd16 && salt_r) verd_nxt = V_SALTED;
        else if (total_r >= min_r) begin
          idx_nxt   = 8'd0;
          sum_nxt   = 28'd0;
          state_nxt = T_BRD;
        end else verd_nxt = V_PLAIN;
      end
      T_BRD: state_nxt = T_BST;
      T_BST: begin
        lg_start  = 1'b1;
        state_nxt = T_BWT;
      end
      T_BWT: begin
        if (lg_done) begin
          sum_nxt   = sum_r + lg_val;
          idx_nxt   = idx_r + 8'd1;
          state_nxt = (idx_r == 8'd255) ? T_TOP : T_BRD;
        end
      end
      T_TOP: begin
        lg_c      = total_r;
        lg_start  = 1'b1;
        state_nxt = T_TWT;
      end
      T_TWT: begin
        if (lg_done) begin
          quo_nxt   = (lg_val > sum_r) ? lg_val - sum_r : 28'd0;
          rem_nxt   = 14'd0;
          dcnt_nxt  = 5'd27;
          state_nxt = T_DIV;
        end
      end
      T_DIV: begin
        // restoring divide by the byte count, one quotient bit a cycle
        if (tr >= {1'b0, total_r}) begin
          rem_nxt = tr - {1'b0, total_r};
          quo_nxt = {quo_r[26:0], 1'b1};
        end else begin
          rem_nxt = tr;
          quo_nxt = {quo_r[26:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd0) state_nxt = T_CMP;
      end
      T_CMP: begin
        ent_nxt   = (quo_r > {12'b0, ENTROPY_CAP}) ? ENTROPY_CAP : quo_r[15:0];
        verd_nxt  = (ent_nxt > thresh_r) ? V_HIGH : V_PLAIN;
        state_nxt = T_OUT;
      end
      T_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          oenc_nxt   = (verd_r >= V_LUKS);
          over_nxt   = verd_r;
          oent_nxt   = ent_r;
          ocnt_nxt   = total_r;
          clr        = 1'b1;
          total_nxt  = '0;
          recent_nxt = '0;
          luks_nxt   = 1'b1;
          salt_nxt   = 1'b1;
          fve_nxt    = 1'b0;
          state_nxt  = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/edd_clogc.sv =====
// ----------------------------------------------------------------------------
// edd_clogc
// Iterative c*log2(c) unit: one mantissa squaring per cycle, then one multiply.
// ----------------------------------------------------------------------------
module edd_clogc import edd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] c,
  output logic        done,
  output logic [27:0] value
);

  lg_state_t   state_r, state_nxt;
  logic [30:0] x_r, x_nxt;
  logic [27:0] res_r, res_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [12:0] c_r, c_nxt;
  logic [27:0] val_r, val_nxt;
  logic        done_r, done_nxt;
  logic [61:0] sq;
  logic [40:0] prod;
  logic [3:0]  k;

  assign sq    = {31'b0, x_r} * {31'b0, x_r};
  assign prod  = {28'b0, c_r} * {13'b0, res_r};
  assign k     = msb13(c);
  assign done  = done_r;
  assign value = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LG_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    step_r <= step_nxt;
    c_r    <= c_nxt;
    val_r  <= val_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    step_nxt  = step_r;
    c_nxt     = c_r;
    val_nxt   = val_r;
    done_nxt  = 1'b0;
    case (state_r)
      LG_IDLE: begin
        if (start) begin
          c_nxt    = c;
          x_nxt    = {18'b0, c} << (5'd30 - {1'b0, k});
          res_nxt  = {4'b0, k, 20'b0} << 4;
          step_nxt = 5'(LOG_FRAC - 1);
          if (c <= 13'd1) begin
            val_nxt  = 28'd0;
            done_nxt = 1'b1;
          end else begin
            state_nxt = LG_SQR;
          end
        end
      end
      LG_SQR: begin
        if (sq[61]) begin
          x_nxt = sq[61:31];
          res_nxt[step_r] = 1'b1;
        end else begin
          x_nxt = sq[60:30];
        end
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd0) state_nxt = LG_MUL;
      end
      LG_MUL: begin
        val_nxt   = prod[39:12];
        done_nxt  = 1'b1;
        state_nxt = LG_IDLE;
      end
      default: state_nxt = LG_IDLE;
    endcase
  end

endmodule
